[rtl/bhp_pkg.sv]
// Shared types, phase encoding, status and error codes for the bitstream header parser.
package bhp_pkg;

	typedef struct packed {
		logic       kind;
		logic [7:0] file_byte;
	} in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  payload_byte;
		logic        last;
		logic [3:0]  error_code;
		logic [31:0] stream_length;
	} out_t;

	typedef enum logic [4:0] {
		PH_F1_HI     = 5'd0,
		PH_F1_LO     = 5'd1,
		PH_MAGIC     = 5'd2,
		PH_F2_HI     = 5'd3,
		PH_F2_LO     = 5'd4,
		PH_A_KEY     = 5'd5,
		PH_A_LEN_HI  = 5'd6,
		PH_A_LEN_LO  = 5'd7,
		PH_A_SKIP    = 5'd8,
		PH_B_KEY     = 5'd9,
		PH_B_LEN_HI  = 5'd10,
		PH_B_LEN_LO  = 5'd11,
		PH_B_SKIP    = 5'd12,
		PH_C_KEY     = 5'd13,
		PH_C_LEN_HI  = 5'd14,
		PH_C_LEN_LO  = 5'd15,
		PH_C_SKIP    = 5'd16,
		PH_D_KEY     = 5'd17,
		PH_D_LEN_HI  = 5'd18,
		PH_D_LEN_LO  = 5'd19,
		PH_D_SKIP    = 5'd20,
		PH_KEY_E     = 5'd21,
		PH_SLEN0     = 5'd22,
		PH_SLEN1     = 5'd23,
		PH_SLEN2     = 5'd24,
		PH_SLEN3     = 5'd25,
		PH_PAYLOAD   = 5'd26,
		PH_DONE      = 5'd27,
		PH_ERROR     = 5'd28
	} phase_t;

	typedef enum logic [1:0] {
		ST_HEADER  = 2'd0,
		ST_PAYLOAD = 2'd1,
		ST_ERROR   = 2'd2,
		ST_IDLE    = 2'd3
	} status_t;

	// position within each a..d group: key, length high, length low, string skip
	localparam logic [1:0] SUB_KEY    = 2'd0;
	localparam logic [1:0] SUB_LEN_HI = 2'd1;
	localparam logic [1:0] SUB_LEN_LO = 2'd2;
	localparam logic [1:0] SUB_SKIP   = 2'd3;

	localparam logic [3:0] ERR_NONE     = 4'd0;
	localparam logic [3:0] ERR_F1_LEN   = 4'd1;
	localparam logic [3:0] ERR_MAGIC    = 4'd2;
	localparam logic [3:0] ERR_F2_LEN   = 4'd3;
	localparam logic [3:0] ERR_KEY_A    = 4'd4;
	localparam logic [3:0] ERR_KEY_E    = 4'd8;
	localparam logic [3:0] ERR_ZERO_LEN = 4'd9;

	localparam logic [7:0]  KEY_A       = 8'h61;
	localparam logic [7:0]  KEY_E       = 8'h65;
	localparam logic [15:0] F1_LEN      = 16'd9;
	localparam logic [15:0] F2_LEN      = 16'd1;
	localparam logic [15:0] MAGIC_LAST  = 16'd8;
	localparam logic [7:0]  MAGIC_EVEN  = 8'h0f;
	localparam logic [7:0]  MAGIC_ODD   = 8'hf0;
	localparam logic [7:0]  MAGIC_TAIL  = 8'h00;

	// Nine-byte magic: alternating 0f/f0, closed by 00
	function automatic logic [7:0] magic_byte(input logic [3:0] idx);
		logic [7:0] b;
		if (idx == MAGIC_LAST[3:0]) begin
			b = MAGIC_TAIL;
		end else if (idx[0]) begin
			b = MAGIC_ODD;
		end else begin
			b = MAGIC_EVEN;
		end
		return b;
	endfunction

endpackage

[rtl/bhp_parser.sv]
// Header parse state, per-beat next-state logic and result formation.
module bhp_parser (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         go,
	input  bhp_pkg::in_t item,
	output bhp_pkg::out_t result
);

	bhp_pkg::phase_t phase_q, phase_d;
	logic [15:0] cnt_q, cnt_d;
	logic [31:0] acc_q, acc_d;
	logic [31:0] left_q, left_d;
	logic [3:0]  err_q, err_d;

	bhp_pkg::status_t st_d;
	logic [7:0]  pay_d;
	logic        last_d;
	logic [4:0]  rel;
	logic [1:0]  grp;
	logic [1:0]  sub;
	logic [15:0] acc16;
	logic [31:0] acc32;
	logic [7:0]  b;

	function automatic logic [7:0] rev8(input logic [7:0] x);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) begin
			r[7 - i] = x[i];
		end
		return r;
	endfunction

	assign b     = item.file_byte;
	assign rel   = phase_q - bhp_pkg::PH_A_KEY;
	assign grp   = rel[3:2];
	assign sub   = rel[1:0];
	assign acc16 = {acc_q[7:0], b};
	assign acc32 = {acc_q[23:0], b};

	// next state
	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q;
		acc_d   = acc_q;
		left_d  = left_q;
		err_d   = err_q;
		st_d    = bhp_pkg::ST_HEADER;
		pay_d   = 8'd0;
		last_d  = 1'b0;
		if (item.kind) begin
			phase_d = bhp_pkg::PH_F1_HI;
			cnt_d   = 16'd0;
			acc_d   = 32'd0;
			left_d  = 32'd0;
			err_d   = bhp_pkg::ERR_NONE;
			st_d    = bhp_pkg::ST_IDLE;
		end else if (phase_q == bhp_pkg::PH_F1_HI || phase_q == bhp_pkg::PH_F2_HI) begin
			acc_d   = {24'd0, b};
			phase_d = bhp_pkg::phase_t'(phase_q + 5'd1);
		end else if (phase_q == bhp_pkg::PH_F1_LO) begin
			acc_d = {16'd0, acc16};
			if (acc16 != bhp_pkg::F1_LEN) begin
				err_d   = bhp_pkg::ERR_F1_LEN;
				phase_d = bhp_pkg::PH_ERROR;
			end else begin
				cnt_d   = 16'd0;
				phase_d = bhp_pkg::PH_MAGIC;
			end
		end else if (phase_q == bhp_pkg::PH_F2_LO) begin
			acc_d = {16'd0, acc16};
			if (acc16 != bhp_pkg::F2_LEN) begin
				err_d   = bhp_pkg::ERR_F2_LEN;
				phase_d = bhp_pkg::PH_ERROR;
			end else begin
				phase_d = bhp_pkg::PH_A_KEY;
			end
		end else if (phase_q == bhp_pkg::PH_MAGIC) begin
			if (cnt_q > bhp_pkg::MAGIC_LAST || b != bhp_pkg::magic_byte(cnt_q[3:0])) begin
				err_d   = bhp_pkg::ERR_MAGIC;
				phase_d = bhp_pkg::PH_ERROR;
			end else if (cnt_q == bhp_pkg::MAGIC_LAST) begin
				phase_d = bhp_pkg::PH_F2_HI;
			end else begin
				cnt_d = cnt_q + 16'd1;
			end
		end else if (phase_q >= bhp_pkg::PH_A_KEY && phase_q < bhp_pkg::PH_KEY_E) begin
			// four groups a..d of key, length high, length low, skip
			unique case (sub)
				bhp_pkg::SUB_KEY: begin
					if (b != bhp_pkg::KEY_A + {6'd0, grp}) begin
						err_d   = bhp_pkg::ERR_KEY_A + {2'd0, grp};
						phase_d = bhp_pkg::PH_ERROR;
					end else begin
						phase_d = bhp_pkg::phase_t'(phase_q + 5'd1);
					end
				end
				bhp_pkg::SUB_LEN_HI: begin
					acc_d   = {24'd0, b};
					phase_d = bhp_pkg::phase_t'(phase_q + 5'd1);
				end
				bhp_pkg::SUB_LEN_LO: begin
					acc_d = {16'd0, acc16};
					cnt_d = acc16;
					// empty string goes straight to the next key
					if (acc16 == 16'd0) begin
						phase_d = bhp_pkg::phase_t'(phase_q + 5'd2);
					end else begin
						phase_d = bhp_pkg::phase_t'(phase_q + 5'd1);
					end
				end
				bhp_pkg::SUB_SKIP: begin
					cnt_d = cnt_q - 16'd1;
					if (cnt_q == 16'd1) begin
						phase_d = bhp_pkg::phase_t'(phase_q + 5'd1);
					end
				end
			endcase
		end else if (phase_q == bhp_pkg::PH_KEY_E) begin
			if (b != bhp_pkg::KEY_E) begin
				err_d   = bhp_pkg::ERR_KEY_E;
				phase_d = bhp_pkg::PH_ERROR;
			end else begin
				acc_d   = 32'd0;
				phase_d = bhp_pkg::PH_SLEN0;
			end
		end else if (phase_q >= bhp_pkg::PH_SLEN0 && phase_q < bhp_pkg::PH_PAYLOAD) begin
			acc_d = acc32;
			if (phase_q == bhp_pkg::PH_SLEN3) begin
				if (acc32 == 32'd0) begin
					err_d   = bhp_pkg::ERR_ZERO_LEN;
					phase_d = bhp_pkg::PH_ERROR;
				end else begin
					left_d  = acc32;
					phase_d = bhp_pkg::PH_PAYLOAD;
				end
			end else begin
				phase_d = bhp_pkg::phase_t'(phase_q + 5'd1);
			end
		end else if (phase_q == bhp_pkg::PH_PAYLOAD) begin
			st_d   = bhp_pkg::ST_PAYLOAD;
			pay_d  = rev8(b);
			left_d = left_q - 32'd1;
			if (left_q == 32'd1) begin
				last_d  = 1'b1;
				phase_d = bhp_pkg::PH_DONE;
			end
		end else if (phase_q == bhp_pkg::PH_DONE) begin
			st_d = bhp_pkg::ST_IDLE;
		end else begin
			phase_d = bhp_pkg::PH_ERROR;
			if (err_q == bhp_pkg::ERR_NONE) begin
				err_d = bhp_pkg::ERR_MAGIC;
			end
		end
	end

	// result fields, taken from the updated state
	always_comb begin
		result.error_code    = err_d;
		result.stream_length = (phase_d == bhp_pkg::PH_PAYLOAD || phase_d == bhp_pkg::PH_DONE)
			? acc_d : 32'd0;
		if (!item.kind && phase_d == bhp_pkg::PH_ERROR) begin
			result.status       = bhp_pkg::ST_ERROR;
			result.payload_byte = 8'd0;
			result.last         = 1'b0;
		end else begin
			result.status       = st_d;
			result.payload_byte = pay_d;
			result.last         = last_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= bhp_pkg::PH_F1_HI;
			cnt_q   <= 16'd0;
			acc_q   <= 32'd0;
			left_q  <= 32'd0;
			err_q   <= bhp_pkg::ERR_NONE;
		end else if (go) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			acc_q   <= acc_d;
			left_q  <= left_d;
			err_q   <= err_d;
		end
	end

	// error phase is sticky until a restart beat
	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		go && !item.kind && phase_q == bhp_pkg::PH_ERROR |=> phase_q == bhp_pkg::PH_ERROR)
		else $error("error phase left without restart");

	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == bhp_pkg::PH_ERROR |-> err_q != bhp_pkg::ERR_NONE)
		else $error("error phase with no error code");

	a_payload_left: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == bhp_pkg::PH_PAYLOAD |-> left_q != 32'd0)
		else $error("payload phase with nothing left");

endmodule

[rtl/bhp_skid.sv]
// Two-entry result buffer between the parser and the output channel.
module bhp_skid (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  bhp_pkg::out_t push_data,
	output logic          room,
	output logic          out_valid,
	input  logic          out_ready,
	output bhp_pkg::out_t out_data
);

	bhp_pkg::out_t ent_q [2];
	logic [1:0] cnt_q;
	logic       wr_q;
	logic       rd_q;
	logic       pop;

	assign room      = cnt_q != 2'd2;
	assign out_valid = cnt_q != 2'd0;
	assign out_data  = ent_q[rd_q];
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> room)
		else $error("beat pushed into full buffer");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("buffer count out of range");

	a_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0 || cnt_q == 2'd2) |-> wr_q == rd_q)
		else $error("buffer pointers disagree with count");

endmodule

[rtl/bitfile_header_parse_bitreverse_top.sv]
// Top level: input register, header parser and result buffer.
//
//  channel | signals                          | accepted when
//  --------+----------------------------------+-------------------------
//  in      | in_valid, in_ready, in_data      | in_valid && in_ready
//  out     | out_valid, out_ready, out_data   | out_valid && out_ready
//
// One beat per cycle while the result buffer has room; each result is registered in the buffer.
// The parser state update in the input register stage sets the rate: one byte, one step.
// A two-entry buffer holds results, so in_ready does not depend on out_ready.
// arst_n clears the parser to the start of the header and empties the buffer.
module bitfile_header_parse_bitreverse_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  bhp_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output bhp_pkg::out_t out_data
);

	logic          valid_s1;
	bhp_pkg::in_t  item_s1;
	logic          room;
	logic          go;
	bhp_pkg::out_t result;

	assign go       = valid_s1 && room;
	assign in_ready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	bhp_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.item   (item_s1),
		.result (result)
	);

	bhp_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (go),
		.push_data (result),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

[tb/sv/bhp_check_pkg.sv]
`timescale 1ns / 100ps
// Scoreboard class for the bitstream header parser bench: header walk prediction and result compare.
package bhp_check_pkg;
	import bhp_pkg::*;

	class header_parse_checker;
		phase_t      phase;
		logic [15:0] skip_left;
		logic [31:0] len_acc;
		logic [31:0] pay_left;
		logic [3:0]  err_latch;
		out_t        due_results[$];
		int unsigned failures;

		function new();
			restart();
			failures = 0;
		endfunction

		function void restart();
			phase     = PH_F1_HI;
			skip_left = '0;
			len_acc   = '0;
			pay_left  = '0;
			err_latch = ERR_NONE;
		endfunction

		function void latch_error(input logic [3:0] code);
			err_latch = code;
			phase     = PH_ERROR;
		endfunction

		function out_t parse_step(input in_t beat);
			out_t       res;
			logic [7:0] b;
			logic [7:0] magic;
			logic [4:0] rel;
			int         i;
			res = '0;
			b = beat.file_byte;
			if (beat.kind) begin
				restart();
				res.status = ST_IDLE;
				return res;
			end
			res.status = ST_HEADER;
			if (phase == PH_F1_HI || phase == PH_F2_HI) begin
				len_acc = {24'd0, b};
				phase = phase_t'(phase + 5'd1);
			end else if (phase == PH_F1_LO) begin
				len_acc = {16'd0, len_acc[7:0], b};
				if (len_acc[15:0] != F1_LEN) begin
					latch_error(ERR_F1_LEN);
				end else begin
					skip_left = '0;
					phase = PH_MAGIC;
				end
			end else if (phase == PH_F2_LO) begin
				len_acc = {16'd0, len_acc[7:0], b};
				if (len_acc[15:0] != F2_LEN) begin
					latch_error(ERR_F2_LEN);
				end else begin
					phase = PH_A_KEY;
				end
			end else if (phase == PH_MAGIC) begin
				magic = (skip_left == MAGIC_LAST) ? MAGIC_TAIL :
					(skip_left[0] ? MAGIC_ODD : MAGIC_EVEN);
				if (skip_left > MAGIC_LAST || b != magic) begin
					latch_error(ERR_MAGIC);
				end else if (skip_left == MAGIC_LAST) begin
					phase = PH_F2_HI;
				end else begin
					skip_left++;
				end
			end else if (phase >= PH_A_KEY && phase < PH_KEY_E) begin
				rel = phase - PH_A_KEY;
				case (rel[1:0])
					SUB_KEY: begin
						if (b != KEY_A + rel[3:2]) begin
							latch_error(ERR_KEY_A + rel[3:2]);
						end else begin
							phase = phase_t'(phase + 5'd1);
						end
					end
					SUB_LEN_HI: begin
						len_acc = {24'd0, b};
						phase = phase_t'(phase + 5'd1);
					end
					SUB_LEN_LO: begin
						len_acc = {16'd0, len_acc[7:0], b};
						skip_left = len_acc[15:0];
						// empty string goes straight on to the next key
						if (skip_left == 16'd0) begin
							phase = phase_t'(phase + 5'd2);
						end else begin
							phase = phase_t'(phase + 5'd1);
						end
					end
					default: begin
						skip_left--;
						if (skip_left == 16'd0) begin
							phase = phase_t'(phase + 5'd1);
						end
					end
				endcase
			end else if (phase == PH_KEY_E) begin
				if (b != KEY_E) begin
					latch_error(ERR_KEY_E);
				end else begin
					len_acc = '0;
					phase = PH_SLEN0;
				end
			end else if (phase >= PH_SLEN0 && phase <= PH_SLEN3) begin
				len_acc = {len_acc[23:0], b};
				if (phase == PH_SLEN3) begin
					if (len_acc == 32'd0) begin
						latch_error(ERR_ZERO_LEN);
					end else begin
						pay_left = len_acc;
						phase = PH_PAYLOAD;
					end
				end else begin
					phase = phase_t'(phase + 5'd1);
				end
			end else if (phase == PH_PAYLOAD) begin
				res.status = ST_PAYLOAD;
				for (i = 0; i < 8; i++) begin
					res.payload_byte[7 - i] = b[i];
				end
				pay_left--;
				if (pay_left == 32'd0) begin
					res.last = 1'b1;
					phase = PH_DONE;
				end
			end else if (phase == PH_DONE) begin
				res.status = ST_IDLE;
			end else begin
				phase = PH_ERROR;
				if (err_latch == ERR_NONE) begin
					err_latch = ERR_MAGIC;
				end
			end

			if (phase == PH_ERROR) begin
				res.status       = ST_ERROR;
				res.payload_byte = '0;
				res.last         = 1'b0;
			end
			res.error_code    = err_latch;
			res.stream_length = (phase == PH_PAYLOAD || phase == PH_DONE) ? len_acc : '0;
			return res;
		endfunction

		function void note_beat(input in_t beat);
			due_results.push_back(parse_step(beat));
		endfunction

		function void flag(input string field, input logic [31:0] want, input logic [31:0] got);
			failures++;
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
		endfunction

		function void check_beat(input out_t got);
			out_t want;
			if (due_results.size() == 0) begin
				failures++;
				$display("%0t: result beat with nothing expected, expected none actual %0h",
					$time, got);
				return;
			end
			want = due_results.pop_front();
			if (got.status !== want.status)
				flag("status", want.status, got.status);
			if (got.payload_byte !== want.payload_byte)
				flag("payload_byte", want.payload_byte, got.payload_byte);
			if (got.last !== want.last)
				flag("last", want.last, got.last);
			if (got.error_code !== want.error_code)
				flag("error_code", want.error_code, got.error_code);
			if (got.stream_length !== want.stream_length)
				flag("stream_length", want.stream_length, got.stream_length);
		endfunction

		function int pending();
			return due_results.size();
		endfunction
	endclass

endpackage

[tb/sv/bitfile_header_parse_bitreverse_top_tb.sv]
`timescale 1ns / 100ps
// Top-level bench for the bitstream header parser: drives files, faults and noise, checks every beat.
module bitfile_header_parse_bitreverse_top_tb;
	import bhp_pkg::*;
	import bhp_check_pkg::*;

	localparam int ITEMS_PER_PHASE = 550;
	localparam int HOLD_CYCLES     = 300;
	localparam int STALL_LIMIT     = 4000;
	localparam int DRAIN_TAIL      = 16;

	// where a header fault is planted
	localparam int FAULT_NONE  = 0;
	localparam int FAULT_F1    = 1;
	localparam int FAULT_MAGIC = 2;
	localparam int FAULT_F2    = 3;
	localparam int FAULT_KEY_A = 4;
	localparam int FAULT_KEY_E = 8;
	localparam int FAULT_ANY   = 9;

	logic clk;
	logic arst_n    = 1'b0;
	logic in_valid  = 1'b0;
	logic in_ready;
	in_t  in_data   = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_data;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int beats_sent    = 0;
	int hold_reqs     = 0;

	header_parse_checker chk = new();

	bitfile_header_parse_bitreverse_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) chk.check_beat(out_data);
			if (in_valid && in_ready) chk.note_beat(in_data);
		end
	end

	// receiver: random stalls, plus a long hold-off whenever one is requested
	initial begin
		int hold_seen;
		int hold_left;
		hold_seen = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_seen != hold_reqs) begin
				hold_seen = hold_reqs;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
			else quiet++;
		end
		$display("bitfile_header_parse_bitreverse_top regression: fail");
		$finish;
	end

	// valid stays up between back-to-back beats; it only drops when a gap is taken
	task automatic send_beat(input in_t beat);
		if (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99, 0) < send_idle_pct) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= beat;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		beats_sent++;
	endtask

	task automatic send_byte(input logic [7:0] b);
		in_t beat;
		beat.kind      = 1'b0;
		beat.file_byte = b;
		send_beat(beat);
	endtask

	task automatic send_restart();
		in_t beat;
		beat.kind      = 1'b1;
		beat.file_byte = 8'($urandom);
		send_beat(beat);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (chk.pending() != 0) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_str_len(input int str_max);
		if (str_max == 0) return '0;
		// now and then a string of 250 to 300 bytes, mostly long enough to use the high length byte
		if ($urandom_range(39, 0) == 0) return 16'($urandom_range(300, 250));
		return 16'($urandom_range(str_max, 0));
	endfunction

	task automatic send_file(input bit restart_first, input int str_max, input logic [31:0] slen,
			input int pay_sent, input int trail, input int fault);
		logic [7:0]  fb[$];
		logic [15:0] sl;
		int          key_at[5];
		int          hdr_len;
		int          pos;
		int          k;
		int          n;
		fb.push_back(F1_LEN[15:8]);
		fb.push_back(F1_LEN[7:0]);
		for (k = 0; k < 9; k++) begin
			fb.push_back((k == MAGIC_LAST) ? MAGIC_TAIL : ((k % 2) ? MAGIC_ODD : MAGIC_EVEN));
		end
		fb.push_back(F2_LEN[15:8]);
		fb.push_back(F2_LEN[7:0]);
		for (k = 0; k < 4; k++) begin
			key_at[k] = fb.size();
			fb.push_back(KEY_A + 8'(k));
			sl = pick_str_len(str_max);
			fb.push_back(sl[15:8]);
			fb.push_back(sl[7:0]);
			for (n = 0; n < sl; n++) fb.push_back(8'($urandom));
		end
		key_at[4] = fb.size();
		fb.push_back(KEY_E);
		for (n = 3; n >= 0; n--) fb.push_back(slen[8*n +: 8]);
		hdr_len = fb.size();
		repeat (pay_sent) fb.push_back(8'($urandom));
		repeat (trail) fb.push_back(8'($urandom));

		if (fault == FAULT_F1) pos = $urandom_range(1, 0);
		else if (fault == FAULT_MAGIC) pos = 2 + $urandom_range(8, 0);
		else if (fault == FAULT_F2) pos = 11 + $urandom_range(1, 0);
		else if (fault >= FAULT_KEY_A && fault <= FAULT_KEY_E) pos = key_at[fault - FAULT_KEY_A];
		else if (fault == FAULT_ANY) pos = $urandom_range(hdr_len - 1, 0);
		else pos = -1;
		if (pos >= 0) fb[pos] = fb[pos] ^ 8'($urandom_range(255, 1));

		if (restart_first) send_restart();
		foreach (fb[j]) send_byte(fb[j]);
	endtask

	task automatic run_mix(input int upto);
		int         pick;
		int         nb;
		logic [31:0] slen;
		bit         rs;
		in_t        junk;
		while (beats_sent < upto) begin
			pick = $urandom_range(99, 0);
			rs = ($urandom_range(9, 0) != 0);
			if (pick < 55) begin
				slen = ($urandom_range(9, 0) == 0) ? $urandom_range(120, 40) : $urandom_range(24, 1);
				send_file(rs, 4, slen, slen, $urandom_range(3, 0), FAULT_NONE);
			end else if (pick < 82) begin
				slen = $urandom_range(12, 1);
				send_file(rs, 4, slen, slen, 0, $urandom_range(FAULT_ANY, FAULT_F1));
			end else if (pick < 87) begin
				send_file(rs, 3, 32'd0, 0, $urandom_range(2, 0), FAULT_NONE);
			end else if (pick < 93) begin
				// huge length, cut short by the next restart
				slen = ($urandom_range(3, 0) == 0) ? 32'hffff_ffff : $urandom;
				send_file(rs, 3, slen, $urandom_range(6, 0), 0, FAULT_NONE);
			end else begin
				nb = $urandom_range(12, 1);
				repeat (nb) begin
					junk.kind      = ($urandom_range(15, 0) == 0);
					junk.file_byte = 8'($urandom);
					send_beat(junk);
				end
			end
		end
	endtask

	initial begin
		int ph;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// short clean file: empty strings, two-byte stream of extreme bytes, one byte past the end
		send_file(1'b1, 0, 32'd2, 0, 0, FAULT_NONE);
		send_byte(8'h00);
		send_byte(8'hff);
		send_byte(8'h80);
		wait_drained();

		for (ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 38 : ((ph == 1) ? 60 : 0);
			recv_idle_pct = (ph == 0) ? 60 : ((ph == 1) ? 38 : 0);
			hold_reqs++;
			run_mix(beats_sent + ITEMS_PER_PHASE);
			wait_drained();
		end

		repeat (DRAIN_TAIL) @(posedge clk);
		if (chk.failures == 0 && chk.pending() == 0) begin
			$display("bitfile_header_parse_bitreverse_top regression: pass");
		end else begin
			$display("bitfile_header_parse_bitreverse_top regression: fail");
		end
		$finish;
	end

endmodule
